@@ rtl/slx_pkg.sv @@
`timescale 1ns / 1ps
package slx_pkg;

  localparam int OffsetBitsDefault = 24;
  localparam int LineBitsDefault   = 20;
  localparam int DepthBitsDefault  = 16;
  localparam int KwMaxLenDefault   = 6;
  localparam int QueueDepth        = 4;

  // token kinds that the scanner names directly
  localparam logic [5:0] K_LPAREN  = 6'd0;
  localparam logic [5:0] K_RPAREN  = 6'd1;
  localparam logic [5:0] K_LBRACE  = 6'd2;
  localparam logic [5:0] K_RBRACE  = 6'd3;
  localparam logic [5:0] K_COMMA   = 6'd4;
  localparam logic [5:0] K_DOT     = 6'd5;
  localparam logic [5:0] K_MINUS   = 6'd6;
  localparam logic [5:0] K_PLUS    = 6'd7;
  localparam logic [5:0] K_SEMI    = 6'd8;
  localparam logic [5:0] K_SLASH   = 6'd9;
  localparam logic [5:0] K_STAR    = 6'd10;
  localparam logic [5:0] K_BANG    = 6'd11;
  localparam logic [5:0] K_EQUAL   = 6'd13;
  localparam logic [5:0] K_GREATER = 6'd15;
  localparam logic [5:0] K_LESS    = 6'd17;
  localparam logic [5:0] K_IDENT   = 6'd19;
  localparam logic [5:0] K_STRING  = 6'd20;
  localparam logic [5:0] K_NUMBER  = 6'd21;
  localparam logic [5:0] K_EOF     = 6'd38;

  localparam logic [1:0] E_NONE       = 2'd0;
  localparam logic [1:0] E_UNEXPECTED = 2'd1;
  localparam logic [1:0] E_OPEN_STR   = 2'd2;
  localparam logic [1:0] E_OPEN_CMT   = 2'd3;

  typedef struct packed {
    logic [5:0]  kind;
    logic [1:0]  err;
    logic [19:0] line;
    logic [23:0] start;
    logic [23:0] len;
  } res_t;

  // one transaction's worth of results, cnt is 1..3
  typedef struct packed {
    logic [1:0] cnt;
    res_t [2:0] res;
  } pkt_t;

  // chars hold the first letter in the low byte, zero above the word
  function automatic logic [5:0] kw_kind(input logic [63:0] chars);
    logic [5:0] k;
    begin
      case (chars)
        64'("dna"):    k = 6'd22;
        64'("ssalc"):  k = 6'd23;
        64'("esle"):   k = 6'd24;
        64'("eslaf"):  k = 6'd25;
        64'("nuf"):    k = 6'd26;
        64'("rof"):    k = 6'd27;
        64'("fi"):     k = 6'd28;
        64'("lin"):    k = 6'd29;
        64'("ro"):     k = 6'd30;
        64'("tnirp"):  k = 6'd31;
        64'("nruter"): k = 6'd32;
        64'("repus"):  k = 6'd33;
        64'("siht"):   k = 6'd34;
        64'("eurt"):   k = 6'd35;
        64'("rav"):    k = 6'd36;
        64'("elihw"):  k = 6'd37;
        default:       k = K_IDENT;
      endcase
      return k;
    end
  endfunction

endpackage

@@ rtl/slx_front.sv @@
`timescale 1ns / 1ps
module slx_front import slx_pkg::*; #(
  parameter int OFFSET_BITS     = OffsetBitsDefault,
  parameter int LINE_BITS       = LineBitsDefault,
  parameter int DEPTH_BITS      = DepthBitsDefault,
  parameter int KEYWORD_MAX_LEN = KwMaxLenDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       push,
  output pkt_t       push_pkt
);

  localparam int CW = $clog2(KEYWORD_MAX_LEN + 1);
  localparam int KW = 8 * KEYWORD_MAX_LEN;

  localparam logic [3:0] M_IDLE      = 4'd0;
  localparam logic [3:0] M_IDENT     = 4'd1;
  localparam logic [3:0] M_NUM_INT   = 4'd2;
  localparam logic [3:0] M_NUM_DOT   = 4'd3;
  localparam logic [3:0] M_NUM_FRAC  = 4'd4;
  localparam logic [3:0] M_STRING    = 4'd5;
  localparam logic [3:0] M_LINE_CMT  = 4'd6;
  localparam logic [3:0] M_BLOCK_CMT = 4'd7;
  localparam logic [3:0] M_OPER      = 4'd8;

  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_BANG    = 3'd1;
  localparam logic [2:0] OP_EQUAL   = 3'd2;
  localparam logic [2:0] OP_LESS    = 3'd3;
  localparam logic [2:0] OP_GREATER = 3'd4;
  localparam logic [2:0] OP_SLASH   = 3'd5;

  localparam logic [1:0] PAIR_NONE  = 2'd0;
  localparam logic [1:0] PAIR_SLASH = 2'd1;
  localparam logic [1:0] PAIR_STAR  = 2'd2;

  logic [3:0]             mode, mode_next;
  logic [2:0]             op, op_next;
  logic [KW-1:0]          chars, chars_next;
  logic [CW-1:0]          kcnt, kcnt_next;
  logic                   toolong, toolong_next;
  logic [DEPTH_BITS-1:0]  depth, depth_next;
  logic [1:0]             pair, pair_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] tbegin, tbegin_next;
  logic [LINE_BITS-1:0]   line, line_next;

  logic                   go;
  logic [1:0]             n;
  res_t [2:0]             slot;
  logic                   sb;
  logic [5:0]             ident_kind;
  logic [OFFSET_BITS-1:0] pos_m1;

  function automatic logic [5:0] op_kind(input logic [2:0] o);
    logic [5:0] k;
    begin
      case (o)
        OP_BANG:    k = K_BANG;
        OP_EQUAL:   k = K_EQUAL;
        OP_LESS:    k = K_LESS;
        OP_GREATER: k = K_GREATER;
        OP_SLASH:   k = K_SLASH;
        default:    k = K_LPAREN;
      endcase
      return k;
    end
  endfunction

  function automatic res_t mk(input logic [5:0] k, input logic [1:0] e,
                              input logic [LINE_BITS-1:0] ln,
                              input logic [OFFSET_BITS-1:0] s,
                              input logic [OFFSET_BITS-1:0] l);
    res_t r;
    logic [31:0] lw, sw, lenw;
    begin
      lw      = 32'(ln);
      sw      = 32'(s);
      lenw    = 32'(l);
      r.kind  = k;
      r.err   = e;
      r.line  = lw[19:0];
      r.start = sw[23:0];
      r.len   = lenw[23:0];
      return r;
    end
  endfunction

  assign go     = in_valid && in_ready;
  assign pos_m1 = pos - 1'b1;
  assign ident_kind = toolong ? K_IDENT : kw_kind(64'(chars));

  always_comb begin
    mode_next    = mode;
    op_next      = op;
    chars_next   = chars;
    kcnt_next    = kcnt;
    toolong_next = toolong;
    depth_next   = depth;
    pair_next    = pair;
    pos_next     = pos;
    tbegin_next  = tbegin;
    line_next    = line;
    n            = 2'd0;
    slot         = '0;
    sb           = 1'b0;
    if (in_end) begin
      case (mode)
        M_IDENT: begin
          slot[n] = mk(ident_kind, E_NONE, line, tbegin, pos - tbegin); n = n + 2'd1;
        end
        M_NUM_INT, M_NUM_FRAC: begin
          slot[n] = mk(K_NUMBER, E_NONE, line, tbegin, pos - tbegin); n = n + 2'd1;
        end
        M_NUM_DOT: begin
          slot[n] = mk(K_NUMBER, E_NONE, line, tbegin, pos_m1 - tbegin); n = n + 2'd1;
          slot[n] = mk(K_DOT, E_NONE, line, pos_m1, OFFSET_BITS'(1)); n = n + 2'd1;
        end
        M_STRING: begin
          slot[n] = mk(6'd0, E_OPEN_STR, line, tbegin, pos - tbegin); n = n + 2'd1;
        end
        M_BLOCK_CMT: begin
          slot[n] = mk(6'd0, E_OPEN_CMT, line, tbegin, pos - tbegin); n = n + 2'd1;
        end
        M_OPER: begin
          slot[n] = mk(op_kind(op), E_NONE, line, tbegin, OFFSET_BITS'(1)); n = n + 2'd1;
        end
        default: ;
      endcase
      slot[n] = mk(K_EOF, E_NONE, line, pos, '0); n = n + 2'd1;
      // end of text puts everything back to the reset values
      mode_next    = M_IDLE;
      op_next      = OP_NONE;
      chars_next   = '0;
      kcnt_next    = '0;
      toolong_next = 1'b0;
      depth_next   = '0;
      pair_next    = PAIR_NONE;
      pos_next     = '0;
      tbegin_next  = '0;
      line_next    = LINE_BITS'(1);
    end else begin
      case (mode)
        M_IDENT: begin
          if (in_byte inside {["a":"z"], ["A":"Z"], "_", ["0":"9"]}) begin
            if (kcnt < CW'(KEYWORD_MAX_LEN)) begin
              chars_next[8*kcnt +: 8] = in_byte;
              kcnt_next = kcnt + 1'b1;
            end else begin
              toolong_next = 1'b1;
            end
          end else begin
            slot[n] = mk(ident_kind, E_NONE, line, tbegin, pos - tbegin); n = n + 2'd1;
            sb = 1'b1;
          end
        end
        M_NUM_INT: begin
          if (in_byte == ".") begin
            mode_next = M_NUM_DOT;
          end else if (!(in_byte inside {["0":"9"]})) begin
            slot[n] = mk(K_NUMBER, E_NONE, line, tbegin, pos - tbegin); n = n + 2'd1;
            sb = 1'b1;
          end
        end
        M_NUM_DOT: begin
          if (in_byte inside {["0":"9"]}) begin
            mode_next = M_NUM_FRAC;
          end else begin
            slot[n] = mk(K_NUMBER, E_NONE, line, tbegin, pos_m1 - tbegin); n = n + 2'd1;
            slot[n] = mk(K_DOT, E_NONE, line, pos_m1, OFFSET_BITS'(1)); n = n + 2'd1;
            sb = 1'b1;
          end
        end
        M_NUM_FRAC: begin
          if (!(in_byte inside {["0":"9"]})) begin
            slot[n] = mk(K_NUMBER, E_NONE, line, tbegin, pos - tbegin); n = n + 2'd1;
            sb = 1'b1;
          end
        end
        M_STRING: begin
          if (in_byte == "\"") begin
            slot[n] = mk(K_STRING, E_NONE, line, tbegin, pos + 1'b1 - tbegin);
            n = n + 2'd1;
            mode_next = M_IDLE;
          end else if (in_byte == "\n") begin
            if (line != '1) line_next = line + 1'b1;
          end
        end
        M_LINE_CMT: begin
          if (in_byte == "\n") sb = 1'b1;
        end
        M_BLOCK_CMT: begin
          pair_next = PAIR_NONE;
          if (pair == PAIR_SLASH && in_byte == "*") begin
            if (depth != '1) depth_next = depth + 1'b1;
          end else if (pair == PAIR_STAR && in_byte == "/") begin
            if (depth != '0) depth_next = depth - 1'b1;
            if (depth_next == '0) mode_next = M_IDLE;
          end else if (in_byte == "\n") begin
            if (line != '1) line_next = line + 1'b1;
          end else if (in_byte == "/") begin
            pair_next = PAIR_SLASH;
          end else if (in_byte == "*") begin
            pair_next = PAIR_STAR;
          end
        end
        M_OPER: begin
          if (op == OP_SLASH) begin
            if (in_byte == "/") begin
              mode_next = M_LINE_CMT;
              op_next   = OP_NONE;
            end else if (in_byte == "*") begin
              mode_next  = M_BLOCK_CMT;
              op_next    = OP_NONE;
              depth_next = DEPTH_BITS'(1);
              pair_next  = PAIR_NONE;
            end else begin
              slot[n] = mk(K_SLASH, E_NONE, line, tbegin, OFFSET_BITS'(1)); n = n + 2'd1;
              sb = 1'b1;
            end
          end else if (in_byte == "=") begin
            slot[n] = mk(op_kind(op) + 6'd1, E_NONE, line, tbegin, OFFSET_BITS'(2));
            n = n + 2'd1;
            mode_next = M_IDLE;
            op_next   = OP_NONE;
          end else begin
            slot[n] = mk(op_kind(op), E_NONE, line, tbegin, OFFSET_BITS'(1)); n = n + 2'd1;
            sb = 1'b1;
          end
        end
        default: sb = 1'b1;
      endcase
      // first byte of a new token
      if (sb) begin
        mode_next   = M_IDLE;
        op_next     = OP_NONE;
        tbegin_next = pos;
        case (in_byte)
          "(": begin slot[n] = mk(K_LPAREN, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          ")": begin slot[n] = mk(K_RPAREN, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          "{": begin slot[n] = mk(K_LBRACE, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          "}": begin slot[n] = mk(K_RBRACE, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          ",": begin slot[n] = mk(K_COMMA, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          ".": begin slot[n] = mk(K_DOT, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          "-": begin slot[n] = mk(K_MINUS, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          "+": begin slot[n] = mk(K_PLUS, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          ";": begin slot[n] = mk(K_SEMI, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          "*": begin slot[n] = mk(K_STAR, E_NONE, line, pos, OFFSET_BITS'(1)); n = n + 2'd1; end
          "!": begin mode_next = M_OPER; op_next = OP_BANG; end
          "=": begin mode_next = M_OPER; op_next = OP_EQUAL; end
          "<": begin mode_next = M_OPER; op_next = OP_LESS; end
          ">": begin mode_next = M_OPER; op_next = OP_GREATER; end
          "/": begin mode_next = M_OPER; op_next = OP_SLASH; end
          " ", 8'h0D, "\t": ;
          "\n": begin
            if (line != '1) line_next = line + 1'b1;
          end
          "\"": mode_next = M_STRING;
          default: begin
            if (in_byte inside {["0":"9"]}) begin
              mode_next = M_NUM_INT;
            end else if (in_byte inside {["a":"z"], ["A":"Z"], "_"}) begin
              mode_next    = M_IDENT;
              chars_next   = KW'(in_byte);
              kcnt_next    = CW'(1);
              toolong_next = 1'b0;
            end else begin
              slot[n] = mk(6'd0, E_UNEXPECTED, line, pos, OFFSET_BITS'(1)); n = n + 2'd1;
            end
          end
        endcase
      end
      pos_next = pos + 1'b1;
    end
  end

  assign push         = go && (n != 2'd0);
  assign push_pkt.cnt = n;
  assign push_pkt.res = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_IDLE;
      op      <= OP_NONE;
      chars   <= '0;
      kcnt    <= '0;
      toolong <= 1'b0;
      depth   <= '0;
      pair    <= PAIR_NONE;
      pos     <= '0;
      tbegin  <= '0;
      line    <= LINE_BITS'(1);
    end else if (go) begin
      mode    <= mode_next;
      op      <= op_next;
      chars   <= chars_next;
      kcnt    <= kcnt_next;
      toolong <= toolong_next;
      depth   <= depth_next;
      pair    <= pair_next;
      pos     <= pos_next;
      tbegin  <= tbegin_next;
      line    <= line_next;
    end
  end

endmodule

@@ rtl/slx_queue.sv @@
`timescale 1ns / 1ps
module slx_queue import slx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  pkt_t push_pkt,
  output logic full,
  input  logic pop,
  output logic empty,
  output pkt_t head
);

  localparam int AW = $clog2(QueueDepth);
  localparam int NW = $clog2(QueueDepth + 1);

  pkt_t          mem [QueueDepth];
  logic [AW-1:0] wptr, rptr;
  logic [NW-1:0] count;

  assign full  = (count == NW'(QueueDepth));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_pkt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == AW'(QueueDepth - 1)) ? '0 : wptr + 1'b1;
      if (pop)  rptr <= (rptr == AW'(QueueDepth - 1)) ? '0 : rptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ rtl/slx_back.sv @@
`timescale 1ns / 1ps
module slx_back import slx_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic empty,
  input  pkt_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res,
  output logic out_last
);

  logic [1:0] idx;

  assign out_valid = !empty;
  assign out_res   = head.res[idx];
  assign out_last  = (idx == head.cnt - 2'd1);
  assign pop       = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_valid && out_ready) begin
      idx <= out_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

@@ rtl/script_lexer.sv @@
`timescale 1ns / 1ps
// script_lexer: streaming scanner for a small scripting language
//
// input stream: one source byte per transaction on s_axis_tdata; s_axis_tuser
// high marks end of text (byte ignored), which flushes any pending token,
// emits end of file and returns the scanner to its reset state
// output stream: one token or error per transaction; m_axis_tlast is high on
// the final result caused by one input transaction (zero to three results)
//
// a result is written into the queue and offered on m_axis from the queue head
// throughput: one input byte per cycle unless the queue is full; output drains
// one result per cycle while m_axis_tready is high; three results take three transfers
// the scanner front writes each byte's results into a four-entry queue and
// the back end reads them out; s_axis_tready drops only while the queue is
// full, so a stalled receiver holds the input off once four entries wait
//
// reset (rst, synchronous): scanner idle, line 1, offset 0, queue empty
module script_lexer import slx_pkg::*; #(
  parameter int OFFSET_BITS     = OffsetBitsDefault,
  parameter int LINE_BITS       = LineBitsDefault,
  parameter int DEPTH_BITS      = DepthBitsDefault,
  parameter int KEYWORD_MAX_LEN = KwMaxLenDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_value
  input  logic        s_axis_tuser,   // end_of_source
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // line_number_out, start_offset, token_length, zero pad
  output logic [7:0]  m_axis_tuser,   // token_kind, error_code
  output logic        m_axis_tlast    // last_of_run
);

  logic full, empty, push, pop;
  pkt_t push_pkt, head;
  res_t res;

  assign s_axis_tready = !full;

  // front: classify each byte and build its results
  slx_front #(
    .OFFSET_BITS    (OFFSET_BITS),
    .LINE_BITS      (LINE_BITS),
    .DEPTH_BITS     (DEPTH_BITS),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .in_byte (s_axis_tdata),
    .in_end  (s_axis_tuser),
    .push    (push),
    .push_pkt(push_pkt)
  );

  // queue of per-byte result bundles decouples the two sides
  slx_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_pkt(push_pkt),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .head    (head)
  );

  // back: hand results out one transaction at a time
  slx_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .head     (head),
    .pop      (pop),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_res  (res),
    .out_last (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, res.len, res.start, res.line};
  assign m_axis_tuser = {res.err, res.kind};

endmodule
